/* rtl/core/ppsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sample FIFO package
// Shared types and constants for the parallel-port sample FIFO core.
// ---------------------------------------------------------------------------
package ppsf_pkg;

  // Width of one sample byte.
  localparam int unsigned SampleW = 8;
  // Width of the status byte on the result.
  localparam int unsigned StatusW = 7;
  // Status value reported while the FIFO is full.
  localparam logic [StatusW-1:0] FullFlag = 7'h40;
  // Bit of the control port that strobes a repeat of the last data byte.
  localparam int unsigned StrobeBit = 2;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpData   = 2'd1,
    OpCtrl   = 2'd2,
    OpStatus = 2'd3
  } op_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [SampleW-1:0] push_data;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/ppsf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sample FIFO cell
// One byte slot of the shifting FIFO. On a pop it takes its upper
// neighbor's byte; on a push it captures the byte if it is the first
// empty slot above the filled ones.
// ---------------------------------------------------------------------------
module ppsf_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ppsf_pkg::cell_ctrl_t             ctrl_i,
  input  logic                             upper_valid_i,
  input  logic [ppsf_pkg::SampleW-1:0]     upper_data_i,
  input  logic                             lower_valid_i,
  output logic                             valid_o,
  output logic                             valid_next_o,
  output logic [ppsf_pkg::SampleW-1:0]     data_o
);
  import ppsf_pkg::*;

  logic               valid_q, valid_d;
  logic [SampleW-1:0] data_q, data_d;

  // Shift down on a pop, capture on a push into the first free slot.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.pop) begin
      valid_d = upper_valid_i;
      data_d  = upper_data_i;
    end else if (ctrl_i.push && !valid_q && lower_valid_i) begin
      valid_d = 1'b1;
      data_d  = ctrl_i.push_data;
    end
  end

  // The occupancy bit is control state; the byte itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o      = valid_q;
  assign valid_next_o = valid_d;
  assign data_o       = data_q;

endmodule
`default_nettype wire

/* rtl/core/ppsf_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Sample FIFO cell chain
// A row of cells with the oldest byte in cell zero. Pops shift the whole
// row down by one slot; pushes land in the lowest empty cell.
// ---------------------------------------------------------------------------
module ppsf_chain #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppsf_pkg::cell_ctrl_t         ctrl_i,
  output logic                         empty_o,
  output logic                         full_next_o,
  output logic [ppsf_pkg::SampleW-1:0] head_data_o
);
  import ppsf_pkg::*;

  logic [QueueDepth-1:0]   valid;
  logic [QueueDepth-1:0]   valid_next;
  logic [SampleW-1:0]      data [QueueDepth];

  // Instantiate the row, wiring each cell to its neighbors.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic               up_valid;
    logic [SampleW-1:0] up_data;
    logic               low_valid;

    if (i == QueueDepth - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_data  = '0;
    end else begin : g_mid
      assign up_valid = valid[i+1];
      assign up_data  = data[i+1];
    end

    if (i == 0) begin : g_bottom
      assign low_valid = 1'b1;
    end else begin : g_upper
      assign low_valid = valid[i-1];
    end

    ppsf_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .upper_valid_i (up_valid),
      .upper_data_i  (up_data),
      .lower_valid_i (low_valid),
      .valid_o       (valid[i]),
      .valid_next_o  (valid_next[i]),
      .data_o        (data[i])
    );
  end

  // Occupancy flags come straight from the end cells.
  assign empty_o     = !valid[0];
  assign full_next_o = valid_next[QueueDepth-1];
  assign head_data_o = data[0];

endmodule
`default_nettype wire

/* rtl/core/parallel_port_sample_fifo_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Parallel-port sample FIFO core
// Sound device front end: a byte FIFO fed by data and control port writes
// and drained by sample ticks.
// ---------------------------------------------------------------------------
// The core takes one item per clock cycle while s_axis_tready is high and
// returns one registered result item for each; the FIFO is a chain of
// QueueDepth byte cells, so a push or a pop acts on them directly. The tuser
// selects the operation: a tick moves the oldest byte into the current
// sample (or zero when the FIFO is empty or the device is disabled), a data
// write pushes its byte, a control write pushes the last data byte again
// on a rising strobe bit, and a status read changes nothing. A byte pushed
// into a full FIFO is dropped. Every result carries the status (0x40 when
// full) and the current sample, as they stand after the item. A two-entry
// output buffer keeps input tready high while one result waits downstream.
// ---------------------------------------------------------------------------
module parallel_port_sample_fifo_core #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: bit 0 is device_enable.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] port_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [6:0] status_byte, [14:7] current_sample
);
  import ppsf_pkg::*;

  localparam int unsigned ResultW = StatusW + SampleW;

  logic               enable_q;
  logic               prev_strobe_q, prev_strobe_d;
  logic [SampleW-1:0] last_data_q, last_data_d;
  logic [SampleW-1:0] held_q, held_d;

  logic               accept;
  op_e                op;
  logic [SampleW-1:0] port_value;
  logic               strobe;
  cell_ctrl_t         ctrl;
  logic               empty;
  logic               full_next;
  logic [SampleW-1:0] head_data;
  logic [ResultW-1:0] result;

  logic               out_valid_q, skid_valid_q;
  logic [ResultW-1:0] out_data_q, skid_data_q;
  logic               take;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign op         = op_e'(s_axis_tuser);
  assign port_value = s_axis_tdata;
  assign strobe     = port_value[StrobeBit];

  // Decode the item into a push or pop command for the cell chain.
  always_comb begin
    ctrl          = '{push: 1'b0, pop: 1'b0, push_data: port_value};
    prev_strobe_d = prev_strobe_q;
    last_data_d   = last_data_q;
    held_d        = held_q;
    if (accept) begin
      case (op)
        OpTick: begin
          if (enable_q && !empty) begin
            ctrl.pop = 1'b1;
            held_d   = head_data;
          end else begin
            held_d   = '0;
          end
        end
        OpData: begin
          ctrl.push   = 1'b1;
          last_data_d = port_value;
        end
        OpCtrl: begin
          ctrl.push      = strobe && !prev_strobe_q;
          ctrl.push_data = last_data_q;
          prev_strobe_d  = strobe;
        end
        default: begin
        end
      endcase
    end
  end

  ppsf_chain #(
    .QueueDepth (QueueDepth)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .empty_o     (empty),
    .full_next_o (full_next),
    .head_data_o (head_data)
  );

  // Result reflects the state after this item.
  assign result = {held_d, (full_next ? FullFlag : StatusW'(0))};

  // Device state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      prev_strobe_q <= 1'b0;
      last_data_q   <= '0;
      held_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      prev_strobe_q <= prev_strobe_d;
      last_data_q   <= last_data_d;
      held_q        <= held_d;
    end
  end

  // Output register with one skid entry behind it.
  assign take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end else if (accept) begin
      if (out_valid_q) begin
        skid_data_q <= result;
      end else begin
        out_data_q <= result;
      end
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

endmodule
`default_nettype wire
